// ===== src/dsp_interface_mailbox_dma_regs_unit_macros.svh =====
// Assertion macros used by the unit controller.
`ifndef DSP_INTERFACE_MAILBOX_DMA_REGS_UNIT_MACROS_SVH
`define DSP_INTERFACE_MAILBOX_DMA_REGS_UNIT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define DIMR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that one condition is followed by another in the next cycle.
`define DIMR_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== src/dimr_pkg.sv =====
package dimr_pkg;

	localparam int unsigned ADDR_W = 8;
	localparam int unsigned DEPTH  = 1 << ADDR_W;

	// command codes
	localparam logic [2:0] CMD_REG_RD   = 3'd0;
	localparam logic [2:0] CMD_REG_WR   = 3'd1;
	localparam logic [2:0] CMD_MB_WR_HI = 3'd2;
	localparam logic [2:0] CMD_MB_WR_LO = 3'd3;
	localparam logic [2:0] CMD_MB_RD_HI = 3'd4;
	localparam logic [2:0] CMD_MB_RD_LO = 3'd5;
	localparam logic [2:0] CMD_MB_PEEK  = 3'd6;

	// special register addresses
	localparam logic [7:0] REG_DSCR  = 8'hc9;
	localparam logic [7:0] REG_DSBL  = 8'hcb;
	localparam logic [7:0] REG_DSPA  = 8'hcd;
	localparam logic [7:0] REG_DSMAH = 8'hce;
	localparam logic [7:0] REG_DSMAL = 8'hcf;
	localparam logic [7:0] REG_ARAM  = 8'hdd;
	localparam logic [7:0] REG_IRQ   = 8'hfb;
	localparam logic [7:0] REG_DMB_H = 8'hfc;
	localparam logic [7:0] REG_DMB_L = 8'hfd;
	localparam logic [7:0] REG_CMB_H = 8'hfe;
	localparam logic [7:0] REG_CMB_L = 8'hff;

	// DMA kinds
	localparam logic [2:0] DMA_NONE     = 3'd0;
	localparam logic [2:0] DMA_DRAM_IN  = 3'd1;
	localparam logic [2:0] DMA_DRAM_OUT = 3'd2;
	localparam logic [2:0] DMA_IRAM_IN  = 3'd3;
	localparam logic [2:0] DMA_IRAM_OUT = 3'd4;
	localparam logic [2:0] DMA_BAD_ADDR = 3'd5;
	localparam logic [2:0] DMA_BAD_CTL  = 3'd6;

	localparam logic [15:0] MB_DATA_MASK = 16'h7fff;
	localparam logic [15:0] MB_FULL      = 16'h8000;
	localparam logic [15:0] DSCR_CLR     = ~16'h0004;
	localparam logic [31:0] IRAM_MASK    = 32'h0fffffff;
	localparam logic [31:0] DRAM_MASK    = 32'h7fffffff;
	localparam logic [31:0] DRAM_LIMIT   = 32'h01ffffff;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

// ===== src/dimr_controller.sv =====
module dimr_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dimr_pkg::dp_cmd_t cmd
);

	dimr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dimr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			dimr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = dimr_pkg::ST_EXEC;
				end
			end
			dimr_pkg::ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = dimr_pkg::ST_OUT;
			end
			dimr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = dimr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dimr_pkg::ST_IDLE;
			end
		endcase
	end

`include "dsp_interface_mailbox_dma_regs_unit_macros.svh"

	`DIMR_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while result pending")
	`DIMR_ASSERT_NEXT(a_cap_exec, cmd.capture, cmd.execute, "capture not followed by execute")
	`DIMR_ASSERT_NEXT(a_exec_out, cmd.execute, out_valid, "execute not followed by result")
	`DIMR_ASSERT_NEXT(a_out_idle, out_valid && out_ready, in_ready, "no return to idle")

endmodule

// ===== src/dimr_datapath.sv =====
module dimr_datapath #(
	parameter int unsigned MAX_DMA_BYTES = 16384
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dimr_pkg::dp_cmd_t cmd,
	input  logic [2:0]        command,
	input  logic              mbox_sel,
	input  logic [7:0]        address,
	input  logic [15:0]       write_data,
	output logic [31:0]       read_data,
	output logic              dsp_irq,
	output logic [2:0]        dma_kind,
	output logic [30:0]       dma_main_address,
	output logic [15:0]       dma_dsp_address,
	output logic [14:0]       dma_length,
	output logic              aram_read
);

	localparam logic [15:0] MaxLen = 16'(MAX_DMA_BYTES);

	// latched beat
	logic [2:0]  cmd_q;
	logic        mb_q;
	logic [7:0]  addr_q;
	logic [15:0] wdata_q;

	// register file memory with per-entry valid bits
	logic [15:0] mem_q [dimr_pkg::DEPTH];
	logic [dimr_pkg::DEPTH-1:0] vld_q;
	logic [15:0] rdata_q;
	logic        rvld_q;
	logic        mem_we;

	// DMA descriptor registers held in flops
	logic [15:0] dscr_q, dsbl_q, dspa_q, dsmah_q, dsmal_q;
	logic [15:0] mb_hi_q [2];
	logic [15:0] mb_lo_q [2];

	// next values
	logic [31:0] rd_d;
	logic        irq_d, aram_d;
	logic [2:0]  kind_d;
	logic [30:0] maddr_d;
	logic [15:0] daddr_d;
	logic [14:0] len_d;
	logic [15:0] mb_hi_d [2];
	logic [15:0] mb_lo_d [2];
	logic [15:0] dscr_d, dsbl_d, dspa_d, dsmah_d, dsmal_d;
	logic        shadow_hit;
	logic [15:0] shadow_rd;
	logic [31:0] raw_addr;
	logic [31:0] iram_addr, dram_addr;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			mb_q    <= mbox_sel;
			addr_q  <= address;
			wdata_q <= write_data;
			rdata_q <= mem_q[address];
		end
		if (mem_we) begin
			mem_q[addr_q] <= wdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rvld_q <= vld_q[address];
			end
			if (mem_we) begin
				vld_q[addr_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		shadow_hit = 1'b1;
		shadow_rd  = '0;
		unique case (addr_q)
			dimr_pkg::REG_DSCR:  shadow_rd = dscr_q;
			dimr_pkg::REG_DSBL:  shadow_rd = dsbl_q;
			dimr_pkg::REG_DSPA:  shadow_rd = dspa_q;
			dimr_pkg::REG_DSMAH: shadow_rd = dsmah_q;
			dimr_pkg::REG_DSMAL: shadow_rd = dsmal_q;
			default:             shadow_hit = 1'b0;
		endcase
	end

	assign raw_addr  = {dsmah_q, dsmal_q};
	assign iram_addr = raw_addr & dimr_pkg::IRAM_MASK;
	assign dram_addr = raw_addr & dimr_pkg::DRAM_MASK;

	always_comb begin
		rd_d    = '0;
		irq_d   = 1'b0;
		aram_d  = 1'b0;
		kind_d  = dimr_pkg::DMA_NONE;
		maddr_d = '0;
		daddr_d = '0;
		len_d   = '0;
		mem_we  = 1'b0;
		mb_hi_d = mb_hi_q;
		mb_lo_d = mb_lo_q;
		dscr_d  = dscr_q;
		dsbl_d  = dsbl_q;
		dspa_d  = dspa_q;
		dsmah_d = dsmah_q;
		dsmal_d = dsmal_q;
		unique case (cmd_q)
			dimr_pkg::CMD_REG_RD: begin
				priority if (addr_q == dimr_pkg::REG_DMB_H) begin
					rd_d = {16'd0, mb_hi_q[0]};
				end else if (addr_q == dimr_pkg::REG_CMB_H) begin
					rd_d = {16'd0, mb_hi_q[1]};
				end else if (addr_q == dimr_pkg::REG_CMB_L) begin
					rd_d       = {16'd0, mb_lo_q[1]};
					mb_hi_d[1] = mb_hi_q[1] & dimr_pkg::MB_DATA_MASK;
				end else if (addr_q == dimr_pkg::REG_ARAM) begin
					aram_d = 1'b1;
				end else if (shadow_hit) begin
					rd_d = {16'd0, shadow_rd};
				end else begin
					// unwritten entries read as zero
					rd_d = rvld_q ? {16'd0, rdata_q} : '0;
				end
			end
			dimr_pkg::CMD_REG_WR: begin
				priority if (addr_q == dimr_pkg::REG_IRQ) begin
					irq_d = wdata_q[0];
				end else if (addr_q == dimr_pkg::REG_DMB_H) begin
					mb_hi_d[0] = wdata_q & dimr_pkg::MB_DATA_MASK;
				end else if (addr_q == dimr_pkg::REG_DMB_L) begin
					mb_lo_d[0] = wdata_q;
					mb_hi_d[0] = mb_hi_q[0] | dimr_pkg::MB_FULL;
				end else if (addr_q == dimr_pkg::REG_DSBL) begin
					// launch with the new length, then drop DSCR bit 2
					dsbl_d = wdata_q;
					dscr_d = dscr_q & dimr_pkg::DSCR_CLR;
					if (dscr_q > 16'd3 || wdata_q > MaxLen) begin
						kind_d = dimr_pkg::DMA_BAD_CTL;
					end else begin
						daddr_d = {dspa_q[14:0], 1'b0};
						len_d   = wdata_q[14:0];
						if (dscr_q[1]) begin
							kind_d  = dscr_q[0] ? dimr_pkg::DMA_IRAM_OUT : dimr_pkg::DMA_IRAM_IN;
							maddr_d = iram_addr[30:0];
						end else begin
							maddr_d = dram_addr[30:0];
							if (dram_addr > dimr_pkg::DRAM_LIMIT) begin
								kind_d = dimr_pkg::DMA_BAD_ADDR;
							end else begin
								kind_d = dscr_q[0] ? dimr_pkg::DMA_DRAM_OUT
								                   : dimr_pkg::DMA_DRAM_IN;
							end
						end
					end
				end else if (addr_q == dimr_pkg::REG_DSCR) begin
					dscr_d = wdata_q;
				end else if (addr_q == dimr_pkg::REG_DSPA) begin
					dspa_d = wdata_q;
				end else if (addr_q == dimr_pkg::REG_DSMAH) begin
					dsmah_d = wdata_q;
				end else if (addr_q == dimr_pkg::REG_DSMAL) begin
					dsmal_d = wdata_q;
				end else begin
					mem_we = cmd.execute;
				end
			end
			dimr_pkg::CMD_MB_WR_HI: begin
				mb_hi_d[mb_q] = wdata_q & dimr_pkg::MB_DATA_MASK;
			end
			dimr_pkg::CMD_MB_WR_LO: begin
				mb_lo_d[mb_q] = wdata_q;
				mb_hi_d[mb_q] = mb_hi_q[mb_q] | dimr_pkg::MB_FULL;
			end
			dimr_pkg::CMD_MB_RD_HI: begin
				rd_d = {16'd0, mb_hi_q[mb_q]};
			end
			dimr_pkg::CMD_MB_RD_LO: begin
				rd_d          = {16'd0, mb_lo_q[mb_q]};
				mb_hi_d[mb_q] = mb_hi_q[mb_q] & dimr_pkg::MB_DATA_MASK;
			end
			dimr_pkg::CMD_MB_PEEK: begin
				rd_d = {mb_hi_q[mb_q], mb_lo_q[mb_q]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_hi_q <= '{default: '0};
			mb_lo_q <= '{default: '0};
			dscr_q  <= '0;
			dsbl_q  <= '0;
			dspa_q  <= '0;
			dsmah_q <= '0;
			dsmal_q <= '0;
		end else if (cmd.execute) begin
			mb_hi_q <= mb_hi_d;
			mb_lo_q <= mb_lo_d;
			dscr_q  <= dscr_d;
			dsbl_q  <= dsbl_d;
			dspa_q  <= dspa_d;
			dsmah_q <= dsmah_d;
			dsmal_q <= dsmal_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			read_data        <= rd_d;
			dsp_irq          <= irq_d;
			aram_read        <= aram_d;
			dma_kind         <= kind_d;
			dma_main_address <= maddr_d;
			dma_dsp_address  <= daddr_d;
			dma_length       <= len_d;
		end
	end

endmodule

// ===== src/dsp_interface_mailbox_dma_regs_unit.sv =====
// DSP interface register file with two mailboxes and a DMA launcher. Each input beat
// carries one command: register read or write on the 256-entry interface file, or a
// write, read or peek of the DSP (0) or CPU (1) mailbox. Writing the low mailbox word
// sets the full flag in bit 15 of the high word; reading the low word clears it. A
// register write to DSBL launches a DMA from DSCR, DSPA, DSMAH, DSMAL and the new
// length, and reports its kind, addresses and length on the result beat; DSCR bit 2
// is then cleared. Every input beat yields exactly one result beat. The accept cycle
// issues the register file read, the next cycle executes the command with the
// registered read data and loads the result register, and the result is then
// offered until taken; the next beat is accepted in the cycle after the result
// leaves. The registered read of the single-port register file sets this sequence.
// The file has a valid flop per entry, so it reads as zero right after reset with
// no clearing pass.
module dsp_interface_mailbox_dma_regs_unit #(
	parameter int unsigned MAX_DMA_BYTES = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic        mbox_sel,
	input  logic [7:0]  address,
	input  logic [15:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        dsp_irq,
	output logic [2:0]  dma_kind,
	output logic [30:0] dma_main_address,
	output logic [15:0] dma_dsp_address,
	output logic [14:0] dma_length,
	output logic        aram_read
);

	dimr_pkg::dp_cmd_t cmd;

	// sequence accept, execute and result hand-off
	dimr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// hold the register file, mailboxes, DMA descriptor and result register
	dimr_datapath #(
		.MAX_DMA_BYTES (MAX_DMA_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.command          (command),
		.mbox_sel         (mbox_sel),
		.address          (address),
		.write_data       (write_data),
		.read_data        (read_data),
		.dsp_irq          (dsp_irq),
		.dma_kind         (dma_kind),
		.dma_main_address (dma_main_address),
		.dma_dsp_address  (dma_dsp_address),
		.dma_length       (dma_length),
		.aram_read        (aram_read)
	);

endmodule

// ===== tb/tb.sv =====
module tb;

	localparam int unsigned MAX_DMA_BYTES  = 16384;
	localparam int          RANDOM_ITEMS   = 1420;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          DRAIN_CYCLES   = 8;

	// the one opcode the package leaves unnamed: does nothing, answers with zeros
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct packed {
		logic [31:0] read_data;
		logic        dsp_irq;
		logic [2:0]  dma_kind;
		logic [30:0] dma_main_address;
		logic [15:0] dma_dsp_address;
		logic [14:0] dma_length;
		logic        aram_read;
	} dsp_reply_t;

	// Tracks the register file and both mailboxes, predicts one reply per
	// command beat and checks reply beats against them in order.
	class dsp_iface_checker;
		logic [15:0] iface_regs [256];
		logic [15:0] mbox_hi [2];
		logic [15:0] mbox_lo [2];
		dsp_reply_t  pending_replies [$];
		int          errors;

		function new();
			foreach (iface_regs[i]) iface_regs[i] = '0;
			foreach (mbox_hi[i]) mbox_hi[i] = '0;
			foreach (mbox_lo[i]) mbox_lo[i] = '0;
			errors = 0;
		endfunction

		function void note_command(logic [2:0] cmd, logic mb, logic [7:0] addr,
				logic [15:0] wdata);
			dsp_reply_t  r;
			logic [15:0] ctl;
			logic [15:0] len;
			logic [31:0] mem_addr;
			r = '0;
			case (cmd)
				dimr_pkg::CMD_REG_RD: begin
					if (addr == dimr_pkg::REG_DMB_H) r.read_data = {16'd0, mbox_hi[0]};
					else if (addr == dimr_pkg::REG_CMB_H) r.read_data = {16'd0, mbox_hi[1]};
					else if (addr == dimr_pkg::REG_CMB_L) begin
						r.read_data = {16'd0, mbox_lo[1]};
						mbox_hi[1] &= dimr_pkg::MB_DATA_MASK;
					end else if (addr == dimr_pkg::REG_ARAM) r.aram_read = 1'b1;
					else r.read_data = {16'd0, iface_regs[addr]};
				end
				dimr_pkg::CMD_REG_WR: begin
					if (addr == dimr_pkg::REG_IRQ) r.dsp_irq = wdata[0];
					else if (addr == dimr_pkg::REG_DMB_H)
						mbox_hi[0] = wdata & dimr_pkg::MB_DATA_MASK;
					else if (addr == dimr_pkg::REG_DMB_L) begin
						mbox_lo[0] = wdata;
						mbox_hi[0] |= dimr_pkg::MB_FULL;
					end else if (addr == dimr_pkg::REG_DSBL) begin
						iface_regs[addr] = wdata;
						ctl = iface_regs[dimr_pkg::REG_DSCR];
						len = iface_regs[dimr_pkg::REG_DSBL];
						mem_addr = {iface_regs[dimr_pkg::REG_DSMAH],
							iface_regs[dimr_pkg::REG_DSMAL]};
						if (ctl > 16'd3 || len > MAX_DMA_BYTES) begin
							r.dma_kind = dimr_pkg::DMA_BAD_CTL;
						end else begin
							if (ctl[1]) begin
								r.dma_kind = ctl[0] ? dimr_pkg::DMA_IRAM_OUT
									: dimr_pkg::DMA_IRAM_IN;
								mem_addr &= dimr_pkg::IRAM_MASK;
							end else begin
								mem_addr &= dimr_pkg::DRAM_MASK;
								if (mem_addr > dimr_pkg::DRAM_LIMIT)
									r.dma_kind = dimr_pkg::DMA_BAD_ADDR;
								else
									r.dma_kind = ctl[0] ? dimr_pkg::DMA_DRAM_OUT
										: dimr_pkg::DMA_DRAM_IN;
							end
							r.dma_main_address = mem_addr[30:0];
							r.dma_dsp_address  = {iface_regs[dimr_pkg::REG_DSPA][14:0], 1'b0};
							r.dma_length       = len[14:0];
						end
						iface_regs[dimr_pkg::REG_DSCR] &= dimr_pkg::DSCR_CLR;
					end else iface_regs[addr] = wdata;
				end
				dimr_pkg::CMD_MB_WR_HI: mbox_hi[mb] = wdata & dimr_pkg::MB_DATA_MASK;
				dimr_pkg::CMD_MB_WR_LO: begin
					mbox_lo[mb] = wdata;
					mbox_hi[mb] |= dimr_pkg::MB_FULL;
				end
				dimr_pkg::CMD_MB_RD_HI: r.read_data = {16'd0, mbox_hi[mb]};
				dimr_pkg::CMD_MB_RD_LO: begin
					r.read_data = {16'd0, mbox_lo[mb]};
					mbox_hi[mb] &= dimr_pkg::MB_DATA_MASK;
				end
				dimr_pkg::CMD_MB_PEEK: r.read_data = {mbox_hi[mb], mbox_lo[mb]};
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(dsp_reply_t got);
			dsp_reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply beat, expected none, actual read_data %h",
					$time, got.read_data);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			check_field("read_data", want.read_data, got.read_data);
			check_field("dsp_irq", 32'(want.dsp_irq), 32'(got.dsp_irq));
			check_field("dma_kind", 32'(want.dma_kind), 32'(got.dma_kind));
			check_field("dma_main_address", 32'(want.dma_main_address),
				32'(got.dma_main_address));
			check_field("dma_dsp_address", 32'(want.dma_dsp_address),
				32'(got.dma_dsp_address));
			check_field("dma_length", 32'(want.dma_length), 32'(got.dma_length));
			check_field("aram_read", 32'(want.aram_read), 32'(got.aram_read));
		endfunction

		function void report_leftovers();
			if (pending_replies.size() != 0) begin
				$display("%0t: %0d replies expected, actual none", $time,
					pending_replies.size());
				errors += pending_replies.size();
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic        mbox_sel;
	logic [7:0]  address;
	logic [15:0] write_data;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] read_data;
	logic        dsp_irq;
	logic [2:0]  dma_kind;
	logic [30:0] dma_main_address;
	logic [15:0] dma_dsp_address;
	logic [14:0] dma_length;
	logic        aram_read;

	dsp_iface_checker board;

	// current traffic shape, in percent of cycles
	int sender_idle_pct;
	int recv_stall_pct;
	int items_sent;

	dsp_interface_mailbox_dma_regs_unit #(
		.MAX_DMA_BYTES(MAX_DMA_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.mbox_sel(mbox_sel),
		.address(address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.dsp_irq(dsp_irq),
		.dma_kind(dma_kind),
		.dma_main_address(dma_main_address),
		.dma_dsp_address(dma_dsp_address),
		.dma_length(dma_length),
		.aram_read(aram_read)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Reply side: everything is sampled right at the edge, before any of the
	// edge's updates land, so the order of processes within the step is moot.
	// The ready for the next cycle is rolled here as well.
	always @(posedge clk) begin : reply_monitor
		dsp_reply_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{read_data, dsp_irq, dma_kind, dma_main_address,
				dma_dsp_address, dma_length, aram_read};
			board.check_reply(got);
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Give up once neither channel has moved a beat for too long. A correct
	// block, even with the random stalls, moves a beat far sooner than this.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Present one command beat and hold it until taken. An idle gap, when
	// rolled, drops valid first; otherwise valid stays high from the previous
	// beat, so valid sees a single assignment per step.
	task automatic issue(input logic [2:0] cmd, input logic mb, input logic [7:0] addr,
			input logic [15:0] wdata);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		mbox_sel   <= mb;
		address    <= addr;
		write_data <= wdata;
		do @(posedge clk); while (!in_ready);
		board.note_command(cmd, mb, addr, wdata);
		items_sent++;
	endtask

	// Program a DMA the way firmware does: set up the descriptor registers,
	// then the length write fires it. Contents lean toward legal transfers
	// but still hit bad control words, long lengths and high dram addresses.
	task automatic dma_burst();
		logic [15:0] ctl;
		logic [15:0] hi;
		logic [15:0] len;
		ctl = ($urandom_range(9) < 7) ? 16'($urandom_range(3)) : 16'($urandom);
		case ($urandom_range(3))
			0: hi = 16'($urandom_range(16'h01ff));
			1: hi = dimr_pkg::MB_FULL | 16'($urandom_range(16'h01ff));
			2: hi = 16'($urandom_range(16'h0200, 16'h0fff));
			default: hi = 16'($urandom);
		endcase
		case ($urandom_range(4))
			0, 1: len = 16'($urandom_range(MAX_DMA_BYTES));
			2: len = 16'(MAX_DMA_BYTES + $urandom_range(1));
			3: len = 16'($urandom_range(2));
			default: len = 16'($urandom);
		endcase
		if ($urandom_range(1))
			issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DSPA, 16'($urandom));
		if ($urandom_range(1))
			issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DSMAH, hi);
		if ($urandom_range(1))
			issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DSMAL, 16'($urandom));
		if ($urandom_range(9) != 0)
			issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DSCR, ctl);
		issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DSBL, len);
		// read back DSCR to see the bit 2 clear
		if ($urandom_range(2) == 0)
			issue(dimr_pkg::CMD_REG_RD, 1'($urandom), dimr_pkg::REG_DSCR, 16'($urandom));
	endtask

	// Post a message into one mailbox, then drain or inspect it through the
	// mailbox commands or the register aliases.
	task automatic mailbox_burst();
		logic mb;
		logic [7:0] alias_addr;
		mb = 1'($urandom);
		if ($urandom_range(3) != 0) begin
			if (!mb && $urandom_range(3) == 0)
				issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DMB_H,
					16'($urandom));
			else
				issue(dimr_pkg::CMD_MB_WR_HI, mb, 8'($urandom), 16'($urandom));
		end
		if ($urandom_range(3) != 0) begin
			if (!mb && $urandom_range(3) == 0)
				issue(dimr_pkg::CMD_REG_WR, 1'($urandom), dimr_pkg::REG_DMB_L,
					16'($urandom));
			else
				issue(dimr_pkg::CMD_MB_WR_LO, mb, 8'($urandom), 16'($urandom));
		end
		repeat ($urandom_range(1, 4)) begin
			alias_addr = mb ? ($urandom_range(1) ? dimr_pkg::REG_CMB_H : dimr_pkg::REG_CMB_L)
				: dimr_pkg::REG_DMB_H;
			case ($urandom_range(3))
				0: issue(dimr_pkg::CMD_MB_RD_HI, mb, 8'($urandom), 16'($urandom));
				1: issue(dimr_pkg::CMD_MB_RD_LO, mb, 8'($urandom), 16'($urandom));
				2: issue(dimr_pkg::CMD_MB_PEEK, mb, 8'($urandom), 16'($urandom));
				default: issue(dimr_pkg::CMD_REG_RD, 1'($urandom), alias_addr, 16'($urandom));
			endcase
		end
	endtask

	initial begin : stimulus
		int idle_by_phase [4];
		int stall_by_phase [4];
		int goal;
		int directed_items;
		logic [7:0] addr;

		idle_by_phase  = '{0, 51, 0, 10};
		stall_by_phase = '{0, 0, 51, 10};
		board = new();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		items_sent      = 0;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		out_ready  <= 1'b0;
		command    <= dimr_pkg::CMD_REG_RD;
		mbox_sel   <= 1'b0;
		address    <= '0;
		write_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: file address zero, every command, the mailbox full flag and
		// its aliases, IRQ and ARAM, and every DMA outcome but dram and iram in.
		issue(dimr_pkg::CMD_REG_WR, 1'b0, 8'h00, 16'hffff);
		issue(dimr_pkg::CMD_REG_RD, 1'b0, 8'h00, 16'h0000);
		issue(dimr_pkg::CMD_MB_WR_HI, 1'b0, 8'h00, 16'hffff);
		issue(dimr_pkg::CMD_MB_WR_LO, 1'b0, 8'h00, 16'ha5a5);
		issue(dimr_pkg::CMD_MB_PEEK, 1'b0, 8'h00, 16'h0000);
		issue(dimr_pkg::CMD_MB_RD_LO, 1'b0, 8'h00, 16'h0000);
		issue(dimr_pkg::CMD_MB_RD_HI, 1'b0, 8'h00, 16'h0000);
		issue(dimr_pkg::CMD_MB_WR_LO, 1'b1, 8'hff, 16'hffff);
		issue(dimr_pkg::CMD_REG_RD, 1'b1, dimr_pkg::REG_CMB_H, 16'h0000);
		issue(dimr_pkg::CMD_REG_RD, 1'b1, dimr_pkg::REG_CMB_L, 16'h0000);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DMB_L, 16'h1234);
		issue(dimr_pkg::CMD_REG_RD, 1'b0, dimr_pkg::REG_DMB_H, 16'h0000);
		issue(dimr_pkg::CMD_REG_RD, 1'b0, dimr_pkg::REG_DMB_L, 16'h0000);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_IRQ, 16'hffff);
		issue(dimr_pkg::CMD_REG_RD, 1'b0, dimr_pkg::REG_ARAM, 16'h0000);
		issue(CMD_UNUSED, 1'b1, 8'hff, 16'hffff);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSPA, 16'hffff);
		// masks down to exactly the dram limit
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSMAH, 16'h81ff);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSMAL, 16'hffff);
		// bad control word, then a repeat launch with DSCR bit 2 cleared
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSCR, 16'h0005);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSBL, 16'(MAX_DMA_BYTES));
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSBL, 16'(MAX_DMA_BYTES));
		// iram out: length one past the limit is refused, then a short length
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSCR, 16'h0003);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSBL, 16'(MAX_DMA_BYTES + 1));
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSBL, 16'h0002);
		// dram address above the limit
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSMAH, 16'h0200);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSCR, 16'h0000);
		issue(dimr_pkg::CMD_REG_WR, 1'b0, dimr_pkg::REG_DSBL, 16'h0000);
		directed_items = items_sent;

		// Random traffic in four shapes: free flowing, sparse sender,
		// stalling receiver, then a little of both.
		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_by_phase[p];
			recv_stall_pct  = stall_by_phase[p];
			goal = directed_items + (p + 1) * RANDOM_ITEMS / 4;
			while (items_sent < goal) begin
				case ($urandom_range(9))
					0, 1, 2: dma_burst();
					3, 4, 5: mailbox_burst();
					default: begin
						// lean toward the DMA and alias corner of the address map
						addr = ($urandom_range(3) == 0) ? 8'(8'hc8 + $urandom_range(55))
							: 8'($urandom);
						issue(3'($urandom), 1'($urandom), addr, 16'($urandom));
					end
				endcase
			end
		end

		in_valid <= 1'b0;
		while (board.pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.report_leftovers();
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
